[hw/rtl/lkf_pkg.sv]
// Shared types and constants for the keyframe fade engine.
`timescale 1ns / 1ps
`default_nettype none

package lkf_pkg;

  localparam int MAX_KEYS  = 16;
  localparam int FRAC_BITS = 16;

  localparam int IDX_W   = $clog2(MAX_KEYS);
  localparam int CNT_W   = $clog2(MAX_KEYS + 1);
  localparam int TIME_W  = 16;
  localparam int COLOR_W = 8;
  localparam int FRAME_W = 10;
  localparam int EL_W    = 17;
  localparam int ACC_W   = COLOR_W + FRAC_BITS;
  localparam int QUO_W   = ACC_W;
  localparam int DIVC_W  = $clog2(QUO_W);
  localparam int PROD_W  = QUO_W + FRAME_W;
  localparam int SUM_W   = PROD_W + 2;
  localparam int NUM_CH  = 3;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [TIME_W-1:0]  time_t;
  typedef logic [TIME_W:0]    dt_t;
  typedef logic [COLOR_W-1:0] col_t;
  typedef logic [COLOR_W:0]   dc_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [EL_W-1:0]    elapsed_t;
  typedef logic [EL_W:0]      el_sum_t;
  typedef logic [ACC_W-1:0]   acc_t;
  typedef logic [QUO_W-1:0]   quo_t;
  typedef logic [DIVC_W-1:0]  divc_t;
  typedef logic [PROD_W-1:0]  prod_t;
  typedef logic [SUM_W-1:0]   sum_t;

  localparam acc_t ACC_TOP = {{COLOR_W{1'b1}}, {FRAC_BITS{1'b0}}};

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] key_index;
    time_t      key_time_ms;
    col_t       key_red;
    col_t       key_green;
    col_t       key_blue;
    logic [4:0] key_count;
    frame_t     frame_ms;
  } cmd_t;

  typedef struct packed {
    col_t red;
    col_t green;
    col_t blue;
    logic active;
  } result_t;

  typedef struct packed {
    time_t key_time;
    col_t  red;
    col_t  green;
    col_t  blue;
  } key_entry_t;

endpackage

`default_nettype wire

[hw/rtl/lkf_key_ram.sv]
// Keyframe table: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module lkf_key_ram (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire lkf_pkg::idx_t       wr_addr,
  input  wire lkf_pkg::key_entry_t wr_data,
  input  wire logic                rd_en,
  input  wire lkf_pkg::idx_t       rd_addr,
  output lkf_pkg::key_entry_t      rd_data
);

  lkf_pkg::key_entry_t mem [lkf_pkg::MAX_KEYS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/lkf_div.sv]
// Restoring divider for the segment slope, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module lkf_div (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire lkf_pkg::quo_t  dividend,
  input  wire lkf_pkg::time_t divisor,
  output logic                busy,
  output lkf_pkg::quo_t       quotient
);

  lkf_pkg::time_t rem;
  lkf_pkg::time_t dvs;
  lkf_pkg::divc_t cnt;

  logic [lkf_pkg::TIME_W:0] trial;
  logic [lkf_pkg::TIME_W:0] diff;
  logic                     ge;

  always_comb begin
    trial = {rem, quotient[lkf_pkg::QUO_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + lkf_pkg::divc_t'(1);
      if (cnt == lkf_pkg::divc_t'(lkf_pkg::QUO_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Quotient bits shift in where the dividend bits shift out.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
    end else if (busy) begin
      rem      <= ge ? diff[lkf_pkg::TIME_W-1:0] : trial[lkf_pkg::TIME_W-1:0];
      quotient <= {quotient[lkf_pkg::QUO_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/led_keyframe_fade_engine_top.sv]
// Keyframe RGB fade engine: command decode, tick sequencer and color accumulators.
//
// Usage: commands arrive on cmd (cmd_valid / cmd_stall). A load item writes one
// keyframe slot, a start item sets the keyframe count and restarts the effect,
// and a tick item advances time by frame_ms while the effect runs and yields one
// item on color (color_valid / color_stall). Loads and starts leave the engine in
// S_IDLE and give no result. For a tick while the effect runs, the color is loaded
// after three table reads through the single read port of the keyframe RAM, the
// wait in S_DIV for the slope dividers (one per channel, 24 quotient bits, one per
// cycle), then multiply, accumulate and emit stages. For a tick while idle the
// engine goes straight to S_EMIT, for the tick that ends the effect it passes
// S_LAST first. cmd_stall is high whenever the state is not S_IDLE, so one tick is
// in work at a time. The result sits in an output register; loads and starts are
// still taken while it waits, and a following tick holds at its end until the
// receiver takes the previous color. Reset clears time, accumulators and the
// running flag, sets the keyframe count to two; the keyframe table is not cleared
// and must be loaded before a start.
`timescale 1ns / 1ps
`default_nettype none

module led_keyframe_fade_engine_top (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cmd_valid,
  output logic                  cmd_stall,
  input  wire lkf_pkg::cmd_t    cmd,
  output logic                  color_valid,
  input  wire logic             color_stall,
  output lkf_pkg::result_t      color
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LAST = 3'd1;
  localparam logic [2:0] S_NEXT = 3'd2;
  localparam logic [2:0] S_PAIR = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_MUL  = 3'd5;
  localparam logic [2:0] S_ACC  = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0] state;

  lkf_pkg::elapsed_t elapsed;
  lkf_pkg::idx_t     next_slot;
  lkf_pkg::cnt_t     used_count;
  logic              running;
  lkf_pkg::acc_t     acc [lkf_pkg::NUM_CH];

  lkf_pkg::frame_t     frame;
  lkf_pkg::key_entry_t hold;
  logic                adv;
  logic                dt_zero;
  logic [lkf_pkg::NUM_CH-1:0] neg;
  lkf_pkg::prod_t      prod [lkf_pkg::NUM_CH];
  lkf_pkg::result_t    res;

  logic                cmd_acc;
  logic                out_free;
  lkf_pkg::el_sum_t    el_sum;
  lkf_pkg::elapsed_t   el_sat;
  logic                finished;
  logic                advance;

  logic                ram_wr;
  logic                ram_rd;
  lkf_pkg::idx_t       ram_rd_addr;
  lkf_pkg::key_entry_t ram_q;
  lkf_pkg::key_entry_t wr_entry;

  lkf_pkg::key_entry_t cur;
  lkf_pkg::key_entry_t nxt;
  lkf_pkg::dt_t        dt;
  lkf_pkg::time_t      dt_abs;
  lkf_pkg::col_t       cur_c [lkf_pkg::NUM_CH];
  lkf_pkg::col_t       nxt_c [lkf_pkg::NUM_CH];
  lkf_pkg::dc_t        dc [lkf_pkg::NUM_CH];
  lkf_pkg::col_t       dc_abs [lkf_pkg::NUM_CH];
  lkf_pkg::quo_t       dvd [lkf_pkg::NUM_CH];
  lkf_pkg::quo_t       quo [lkf_pkg::NUM_CH];
  logic [lkf_pkg::NUM_CH-1:0] div_busy;
  logic                div_start;

  lkf_pkg::sum_t       sum [lkf_pkg::NUM_CH];
  lkf_pkg::acc_t       acc_next [lkf_pkg::NUM_CH];

  assign cmd_stall = (state != S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign out_free  = !color_valid || !color_stall;

  assign el_sum   = lkf_pkg::el_sum_t'(elapsed) + lkf_pkg::el_sum_t'(cmd.frame_ms);
  assign el_sat   = el_sum[lkf_pkg::EL_W] ? '1 : el_sum[lkf_pkg::EL_W-1:0];
  assign finished = elapsed >= lkf_pkg::elapsed_t'(ram_q.key_time);
  assign advance  = (elapsed >= lkf_pkg::elapsed_t'(ram_q.key_time)) &&
                    ((lkf_pkg::cnt_t'(next_slot) + lkf_pkg::cnt_t'(1)) < used_count);

  assign ram_wr   = cmd_acc && (cmd.req_type == lkf_pkg::REQ_LOAD) &&
                    (32'(cmd.key_index) < lkf_pkg::MAX_KEYS);
  assign wr_entry = '{key_time: cmd.key_time_ms, red: cmd.key_red,
                      green: cmd.key_green, blue: cmd.key_blue};

  // Table read sequence: last key, then the next key, then the other end of the segment.
  always_comb begin
    ram_rd      = 1'b0;
    ram_rd_addr = next_slot;
    unique case (state)
      S_IDLE: begin
        ram_rd      = cmd_acc && (cmd.req_type == lkf_pkg::REQ_TICK) && running;
        ram_rd_addr = lkf_pkg::idx_t'(used_count - lkf_pkg::cnt_t'(1));
      end
      S_LAST: begin
        ram_rd      = !finished;
        ram_rd_addr = next_slot;
      end
      S_NEXT: begin
        ram_rd      = 1'b1;
        ram_rd_addr = advance ? next_slot + lkf_pkg::idx_t'(1)
                              : next_slot - lkf_pkg::idx_t'(1);
      end
      S_PAIR, S_DIV, S_MUL, S_ACC, S_EMIT: begin
        ram_rd      = 1'b0;
        ram_rd_addr = next_slot;
      end
      default: begin
        ram_rd      = 1'b0;
        ram_rd_addr = next_slot;
      end
    endcase
  end

  lkf_key_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_wr),
    .wr_addr (lkf_pkg::idx_t'(cmd.key_index)),
    .wr_data (wr_entry),
    .rd_en   (ram_rd),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_q)
  );

  // Segment endpoints and slope operands.
  always_comb begin
    cur    = adv ? hold : ram_q;
    nxt    = adv ? ram_q : hold;
    dt     = {1'b0, nxt.key_time} - {1'b0, cur.key_time};
    dt_abs = dt[lkf_pkg::TIME_W] ? lkf_pkg::time_t'(~dt + lkf_pkg::dt_t'(1))
                                 : dt[lkf_pkg::TIME_W-1:0];
    cur_c[0] = cur.red;
    cur_c[1] = cur.green;
    cur_c[2] = cur.blue;
    nxt_c[0] = nxt.red;
    nxt_c[1] = nxt.green;
    nxt_c[2] = nxt.blue;
    for (int i = 0; i < lkf_pkg::NUM_CH; i++) begin
      dc[i]     = {1'b0, nxt_c[i]} - {1'b0, cur_c[i]};
      dc_abs[i] = dc[i][lkf_pkg::COLOR_W] ? lkf_pkg::col_t'(~dc[i] + lkf_pkg::dc_t'(1))
                                          : dc[i][lkf_pkg::COLOR_W-1:0];
      dvd[i]    = lkf_pkg::quo_t'(dc_abs[i]) << lkf_pkg::FRAC_BITS;
    end
  end

  assign div_start = (state == S_PAIR);

  for (genvar g = 0; g < lkf_pkg::NUM_CH; g++) begin : g_div
    lkf_div u_div (
      .clk      (clk),
      .rst      (rst),
      .start    (div_start),
      .dividend (dvd[g]),
      .divisor  (dt_abs),
      .busy     (div_busy[g]),
      .quotient (quo[g])
    );
  end

  // Apply signed increment and clamp to 0 .. 255.0 in Q8.16.
  always_comb begin
    for (int i = 0; i < lkf_pkg::NUM_CH; i++) begin
      sum[i] = neg[i] ? lkf_pkg::sum_t'(acc[i]) - lkf_pkg::sum_t'(prod[i])
                      : lkf_pkg::sum_t'(acc[i]) + lkf_pkg::sum_t'(prod[i]);
      if (sum[i][lkf_pkg::SUM_W-1]) begin
        acc_next[i] = '0;
      end else if (sum[i] > lkf_pkg::sum_t'(lkf_pkg::ACC_TOP)) begin
        acc_next[i] = lkf_pkg::ACC_TOP;
      end else begin
        acc_next[i] = sum[i][lkf_pkg::ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      elapsed    <= '0;
      next_slot  <= lkf_pkg::idx_t'(1);
      used_count <= lkf_pkg::cnt_t'(2);
      running    <= 1'b0;
      for (int i = 0; i < lkf_pkg::NUM_CH; i++) begin
        acc[i] <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            if (cmd.req_type == lkf_pkg::REQ_START) begin
              if (32'(cmd.key_count) > lkf_pkg::MAX_KEYS) begin
                used_count <= lkf_pkg::cnt_t'(lkf_pkg::MAX_KEYS);
              end else if (cmd.key_count < 5'd2) begin
                used_count <= lkf_pkg::cnt_t'(2);
              end else begin
                used_count <= lkf_pkg::cnt_t'(cmd.key_count);
              end
              next_slot <= lkf_pkg::idx_t'(1);
              elapsed   <= '0;
              running   <= 1'b1;
              for (int i = 0; i < lkf_pkg::NUM_CH; i++) begin
                acc[i] <= '0;
              end
            end else if (cmd.req_type == lkf_pkg::REQ_TICK) begin
              if (running) begin
                elapsed <= el_sat;
                state   <= S_LAST;
              end else begin
                state <= S_EMIT;
              end
            end
          end
        end
        S_LAST: begin
          if (finished) begin
            running <= 1'b0;
            state   <= S_EMIT;
          end else begin
            state <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (advance) begin
            next_slot <= next_slot + lkf_pkg::idx_t'(1);
          end
          state <= S_PAIR;
        end
        S_PAIR: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_busy == '0) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          for (int i = 0; i < lkf_pkg::NUM_CH; i++) begin
            acc[i] <= acc_next[i];
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath holding registers.
  always_ff @(posedge clk) begin
    if (cmd_acc && (cmd.req_type == lkf_pkg::REQ_TICK)) begin
      frame <= cmd.frame_ms;
      res   <= '0;
    end
    if (state == S_LAST && finished) begin
      res <= '0;
    end
    if (state == S_NEXT) begin
      hold <= ram_q;
      adv  <= advance;
    end
    if (state == S_PAIR) begin
      dt_zero <= (dt == '0);
      for (int i = 0; i < lkf_pkg::NUM_CH; i++) begin
        neg[i] <= dc[i][lkf_pkg::COLOR_W] != dt[lkf_pkg::TIME_W];
      end
    end
    if (state == S_MUL) begin
      for (int i = 0; i < lkf_pkg::NUM_CH; i++) begin
        prod[i] <= (dt_zero ? '0 : lkf_pkg::prod_t'(quo[i])) * lkf_pkg::prod_t'(frame);
      end
    end
    if (state == S_ACC) begin
      res.red    <= acc_next[0][lkf_pkg::ACC_W-1:lkf_pkg::FRAC_BITS];
      res.green  <= acc_next[1][lkf_pkg::ACC_W-1:lkf_pkg::FRAC_BITS];
      res.blue   <= acc_next[2][lkf_pkg::ACC_W-1:lkf_pkg::FRAC_BITS];
      res.active <= 1'b1;
    end
  end

  // Output register: load when empty or being taken, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      color_valid <= 1'b1;
    end else if (!color_stall) begin
      color_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      color <= res;
    end
  end

endmodule

`default_nettype wire

[test/fade_color_checker.sv]
// Channel monitor for the fade engine: predicts each tick's color and compares it.
`timescale 1ns / 1ps

module fade_color_checker
  import lkf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  logic    cmd_stall,
  input  cmd_t    cmd,
  input  logic    color_valid,
  input  logic    color_stall,
  input  result_t color,
  output int      mismatches,
  output int      colors_pending
);

  localparam int ELAPSED_MAX = (1 << EL_W) - 1;

  key_entry_t keys [MAX_KEYS];
  int         elapsed;
  int         seg_slot;
  int         key_total;
  longint     level [NUM_CH];
  logic       playing;
  result_t    expected_colors [$];
  result_t    want;

  // Move one channel along the current segment and clamp to the 0..255 range.
  function automatic longint ramp_channel(longint lvl, int c0, int c1, longint span,
                                          int frame_len);
    longint dc;
    longint mag;
    longint inc;
    longint top;
    dc  = longint'(c1) - longint'(c0);
    top = longint'(255) << FRAC_BITS;
    if (span != 0) begin
      mag = ((dc < 0 ? -dc : dc) << FRAC_BITS) / (span < 0 ? -span : span);
      inc = mag * frame_len;
      if ((dc < 0) != (span < 0)) inc = -inc;
      lvl += inc;
    end
    if (lvl < 0) lvl = 0;
    if (lvl > top) lvl = top;
    return lvl;
  endfunction

  task automatic take_cmd(input cmd_t c);
    result_t    res;
    int         n;
    key_entry_t cur;
    key_entry_t nxt;
    longint     span;
    res = '0;
    case (c.req_type)
      REQ_LOAD: begin
        if (int'(c.key_index) < MAX_KEYS)
          keys[c.key_index] = '{key_time: c.key_time_ms, red: c.key_red,
                                green: c.key_green, blue: c.key_blue};
      end
      REQ_START: begin
        n = int'(c.key_count);
        if (n < 2) n = 2;
        if (n > MAX_KEYS) n = MAX_KEYS;
        key_total = n;
        seg_slot  = 1;
        elapsed   = 0;
        level     = '{default: 0};
        playing   = 1'b1;
      end
      REQ_TICK: begin
        if (playing) begin
          elapsed += int'(c.frame_ms);
          if (elapsed > ELAPSED_MAX) elapsed = ELAPSED_MAX;
          if (elapsed >= int'(keys[key_total-1].key_time)) begin
            playing = 1'b0;
          end else begin
            // advance at most one keyframe per tick, never past the last one
            if (elapsed >= int'(keys[seg_slot].key_time) && seg_slot + 1 < key_total)
              seg_slot++;
            cur  = keys[seg_slot-1];
            nxt  = keys[seg_slot];
            span = longint'(nxt.key_time) - longint'(cur.key_time);
            level[0] = ramp_channel(level[0], int'(cur.red), int'(nxt.red), span,
                                    int'(c.frame_ms));
            level[1] = ramp_channel(level[1], int'(cur.green), int'(nxt.green), span,
                                    int'(c.frame_ms));
            level[2] = ramp_channel(level[2], int'(cur.blue), int'(nxt.blue), span,
                                    int'(c.frame_ms));
            res.red    = col_t'(level[0] >> FRAC_BITS);
            res.green  = col_t'(level[1] >> FRAC_BITS);
            res.blue   = col_t'(level[2] >> FRAC_BITS);
            res.active = 1'b1;
          end
        end
        expected_colors.push_back(res);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      elapsed   = 0;
      seg_slot  = 1;
      key_total = 2;
      level     = '{default: 0};
      playing   = 1'b0;
      expected_colors.delete();
    end else begin
      // compare first: an item taken on this edge cannot have its color out yet
      if (color_valid && !color_stall) begin
        if (expected_colors.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: color item with none expected: r=%0d g=%0d b=%0d active=%0b",
                     $time, color.red, color.green, color.blue, color.active);
        end else begin
          want = expected_colors.pop_front();
          if (color.red !== want.red || color.green !== want.green ||
              color.blue !== want.blue || color.active !== want.active) begin
            mismatches++;
            if (mismatches <= 10) begin
              $write("%0t: color mismatch: expected r=%0d g=%0d b=%0d active=%0b,",
                     $time, want.red, want.green, want.blue, want.active);
              $display(" got r=%0d g=%0d b=%0d active=%0b",
                       color.red, color.green, color.blue, color.active);
            end
          end
        end
      end
      if (cmd_valid && !cmd_stall) take_cmd(cmd);
    end
    colors_pending = expected_colors.size();
  end

endmodule

[test/tb_led_keyframe_fade_engine_top.sv]
// Stimulus, receiver and verdict for the keyframe fade engine.
`timescale 1ns / 1ps

module tb_led_keyframe_fade_engine_top;
  import lkf_pkg::*;

  localparam logic [1:0] REQ_NONE = 2'd3;  // unused code, the block drops it
  localparam int ITEM_GOAL       = 1500;
  localparam int MAX_GAP         = 11;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_LIMIT      = 5000;
  localparam int DRAIN_CYCLES    = 40;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    cmd_valid = 1'b0;
  logic    cmd_stall;
  cmd_t    cmd = '0;
  logic    color_valid;
  logic    color_stall = 1'b0;
  result_t color;
  int      mismatches;
  int      colors_pending;
  int      items_sent;
  int      send_gap_max = MAX_GAP;
  int      take_gap_max = MAX_GAP;
  bit      hold_off_req;
  int      quiet_cycles;

  led_keyframe_fade_engine_top i_dut (
    .clk, .rst, .cmd_valid, .cmd_stall, .cmd, .color_valid, .color_stall, .color
  );

  fade_color_checker i_checker (
    .clk, .rst, .cmd_valid, .cmd_stall, .cmd, .color_valid, .color_stall, .color,
    .mismatches, .colors_pending
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (color_valid && !color_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("led_keyframe_fade_engine_top test failed");
      $finish;
    end
  end

  // Random bits in every field; callers overwrite the ones that matter.
  function automatic cmd_t rand_cmd();
    logic [63:0] bits;
    bits = {$urandom, $urandom};
    return bits[$bits(cmd_t)-1:0];
  endfunction

  function automatic cmd_t load_cmd(int idx, int t, col_t r, col_t g, col_t b);
    cmd_t c;
    c = rand_cmd();
    c.req_type    = REQ_LOAD;
    c.key_index   = 4'(idx);
    c.key_time_ms = time_t'(t);
    c.key_red     = r;
    c.key_green   = g;
    c.key_blue    = b;
    return c;
  endfunction

  function automatic cmd_t start_cmd(int n);
    cmd_t c;
    c = rand_cmd();
    c.req_type  = REQ_START;
    c.key_count = 5'(n);
    return c;
  endfunction

  function automatic cmd_t tick_cmd(int f);
    cmd_t c;
    c = rand_cmd();
    c.req_type = REQ_TICK;
    c.frame_ms = frame_t'(f);
    return c;
  endfunction

  function automatic col_t pick_color();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return col_t'($urandom_range(0, 255));
  endfunction

  task automatic send_cmd(input cmd_t c);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd       <= c;
    cmd_valid <= 1'b1;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    items_sent++;
  endtask

  // Load a fresh table, start it and tick until the effect has run out.
  task automatic run_effect();
    int   n;
    int   t;
    int   r;
    int   frame_top;
    int   played;
    int   f;
    cmd_t c;
    n = ($urandom_range(0, 3) != 0) ? $urandom_range(2, 6) : $urandom_range(2, MAX_KEYS);
    t = $urandom_range(0, 20);
    for (int i = 0; i < n; i++) begin
      if (i > 0) begin
        r = $urandom_range(0, 9);
        if (r == 1) begin
          t = (t > 60) ? t - $urandom_range(1, 60) : 0;
        end else if (r != 0) begin
          t += $urandom_range(1, 150);
        end
      end
      send_cmd(load_cmd(i, t, pick_color(), pick_color(), pick_color()));
    end
    send_cmd(start_cmd(n));
    case ($urandom_range(0, 15))
      0:       frame_top = 1023;
      1, 2, 3: frame_top = 7;
      4, 5, 6: frame_top = 150;
      default: frame_top = 40;
    endcase
    played = 0;
    while (played < t) begin
      if ($urandom_range(0, 19) == 0) begin
        c = rand_cmd();
        c.req_type = $urandom_range(0, 1) ? REQ_LOAD : REQ_NONE;
        send_cmd(c);
      end
      f = (played == 0 && $urandom_range(0, 1)) ? 0 : $urandom_range(0, frame_top);
      send_cmd(tick_cmd(f));
      played += f;
    end
    // up to two ticks after the end land on the idle engine
    repeat ($urandom_range(0, 2)) send_cmd(tick_cmd($urandom_range(0, 1023)));
  endtask

  initial begin
    cmd_t c;
    int   effect_no;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    send_cmd(tick_cmd(1023));
    c = rand_cmd();
    c.req_type = REQ_NONE;
    send_cmd(c);
    for (int i = 0; i < MAX_KEYS; i++) begin
      case (i)
        0:  send_cmd(load_cmd(i, 0, 8'h00, 8'hFF, 8'h00));
        1:  send_cmd(load_cmd(i, 100, 8'hFF, 8'h00, 8'hFF));
        2:  send_cmd(load_cmd(i, 100, 8'h00, 8'h00, 8'h00));  // zero-length segment
        3:  send_cmd(load_cmd(i, 10, 8'hFF, 8'hFF, 8'hFF));   // time runs backward
        14: send_cmd(load_cmd(i, 65535, 8'hFF, 8'hFF, 8'hFF));
        15: send_cmd(load_cmd(i, 1000, 8'h00, 8'h00, 8'h00));
        default: send_cmd(load_cmd(i, 100 + i * 60, pick_color(), pick_color(),
                                   pick_color()));
      endcase
    end
    // count below range saturates to two keys
    send_cmd(start_cmd(0));
    send_cmd(tick_cmd(0));
    send_cmd(tick_cmd(40));
    send_cmd(tick_cmd(1023));
    // count above range saturates to the full table
    send_cmd(start_cmd(31));
    send_cmd(tick_cmd(50));
    send_cmd(tick_cmd(60));
    send_cmd(tick_cmd(60));
    send_cmd(tick_cmd(1023));

    effect_no = 0;
    while (items_sent < ITEM_GOAL) begin
      effect_no++;
      send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
      if (effect_no % 25 == 5) hold_off_req = 1'b1;
      if ($urandom_range(0, 6) == 0) begin
        repeat ($urandom_range(1, 6)) send_cmd(rand_cmd());
      end else begin
        run_effect();
      end
    end

    cmd_valid <= 1'b0;
    while (colors_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && colors_pending == 0) begin
      $display("led_keyframe_fade_engine_top test passed");
    end else begin
      $display("led_keyframe_fade_engine_top test failed");
    end
    $finish;
  end

  // Color receiver: random stall before each item, now and then a long hold-off.
  initial begin
    int wait_cycles;
    int taken;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        color_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        if (taken % 64 == 0) take_gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
        wait_cycles = $urandom_range(0, take_gap_max);
        if (wait_cycles > 0) begin
          color_stall <= 1'b1;
          repeat (wait_cycles) @(posedge clk);
        end
      end
      color_stall <= 1'b0;
      @(posedge clk);
      while (color_valid !== 1'b1) @(posedge clk);
      taken++;
    end
  end

endmodule
